// File: src/assert_macros.svh
// Assertion macros used by the RTL top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the default clk_i / rst_ni pair.
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: src/tccw_pkg.sv
// Package for the text console character writer: constants, codes and
// controller/datapath command and status types. No dependencies.
package tccw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int POS_W      = 11;
  localparam int CELL_W     = 16;
  localparam int TAB_CNT_W  = 3;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [TAB_CNT_W-1:0] TAB_WIDTH = 3'd4;
  localparam logic [ATTR_W-1:0]    ATTR_RESET = 8'h07;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_IDX_COLOR = 1'b0;

  typedef enum logic [2:0] {
    CC_READ,
    CC_NEWLINE,
    CC_RETURN,
    CC_BACKSPACE,
    CC_TAB,
    CC_PRINT
  } chr_class_e;

  typedef struct packed {
    logic capture;
    logic start;
    logic init_step;
    logic clear_step;
    logic rd;
    logic newline;
    logic cr;
    logic bs_move;
    logic bs_blank;
    logic store;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    chr_class_e kind;
    logic       at_bottom;
    logic       wrap_bottom;
    logic       tab_more;
    logic       tab_pending;
    logic       clr_last;
    logic       out_free;
  } status_t;

endpackage

// File: src/tccw_ifs.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on tccw_pkg.
interface tccw_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [tccw_pkg::CHAR_W-1:0]   char_code;
  logic [tccw_pkg::IDX_W-1:0]    cell_index;

  modport source (output valid, req_type, char_code, cell_index, input ready);
  modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tccw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tccw_pkg::POS_W-1:0]    cursor_position;
  logic [tccw_pkg::CELL_W-1:0]   cell_data;
  logic                          screen_cleared;

  modport source (output valid, cursor_position, cell_data, screen_cleared, input ready);
  modport sink   (input valid, cursor_position, cell_data, screen_cleared, output ready);
endinterface

// File: src/tccw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/tccw_ctrl.sv
// Controller FSM: sequences decode, cell stores, screen sweeps and result load.
// Depends on tccw_pkg.
module tccw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tccw_pkg::status_t status_i,
  output tccw_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_STORE  = 3'd3;
  localparam logic [2:0] S_BS_WR  = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = 1'b1;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.start = 1'b1;
        case (status_i.kind)
          tccw_pkg::CC_READ: begin
            cmd_o.rd = 1'b1;
            state_d  = S_DONE;
          end
          tccw_pkg::CC_NEWLINE: begin
            cmd_o.newline = 1'b1;
            state_d       = status_i.at_bottom ? S_CLEAR : S_DONE;
          end
          tccw_pkg::CC_RETURN: begin
            cmd_o.cr = 1'b1;
            state_d  = S_DONE;
          end
          tccw_pkg::CC_BACKSPACE: begin
            cmd_o.bs_move = 1'b1;
            state_d       = S_BS_WR;
          end
          tccw_pkg::CC_TAB, tccw_pkg::CC_PRINT: begin
            state_d = S_STORE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        if (status_i.wrap_bottom) begin
          state_d = S_CLEAR;
        end else if (!status_i.tab_more) begin
          state_d = S_DONE;
        end
      end
      S_BS_WR: begin
        cmd_o.bs_blank = 1'b1;
        state_d        = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = status_i.tab_pending ? S_STORE : S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/tccw_dp.sv
// Datapath: cursor, tab and sweep counters, screen RAM and result register.
// Depends on tccw_pkg and tccw_ram.
module tccw_dp #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tccw_pkg::cmd_t                cmd_i,
  output tccw_pkg::status_t             status_o,
  input  logic [tccw_pkg::ATTR_W-1:0]   attr_i,
  input  logic                          req_type_i,
  input  logic [tccw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tccw_pkg::IDX_W-1:0]    cell_index_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tccw_pkg::POS_W-1:0]    cursor_position_o,
  output logic [tccw_pkg::CELL_W-1:0]   cell_data_o,
  output logic                          screen_cleared_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int XW    = (AW > tccw_pkg::IDX_W) ? AW : tccw_pkg::IDX_W;

  // captured request
  logic                          req_q;
  logic [tccw_pkg::CHAR_W-1:0]   ch_q;
  logic [tccw_pkg::IDX_W-1:0]    idx_q;

  logic [CW-1:0]                  col_q, col_d;
  logic [RW-1:0]                  row_q, row_d;
  logic [tccw_pkg::TAB_CNT_W-1:0] tab_q, tab_d;
  logic [AW-1:0]                  clr_q, clr_d;
  logic                           cleared_q, cleared_d;

  logic                          out_valid_q, out_valid_d;
  logic [tccw_pkg::POS_W-1:0]    out_pos_q;
  logic [tccw_pkg::CELL_W-1:0]   out_data_q;
  logic                          out_clr_q;

  logic [AW-1:0]                 pos;
  logic                          col_last, row_last, clr_last, in_range;
  logic [XW-1:0]                 idx_ext;
  logic [tccw_pkg::CHAR_W-1:0]   store_ch;
  logic [tccw_pkg::CELL_W-1:0]   blank_cell;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [tccw_pkg::CELL_W-1:0]   ram_wdata;
  logic [tccw_pkg::CELL_W-1:0]   ram_rdata;
  tccw_pkg::chr_class_e          kind;

  assign pos      = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign col_last = (col_q == CW'(COLUMNS - 1));
  assign row_last = (row_q == RW'(ROWS - 1));
  assign clr_last = (clr_q == AW'(CELLS - 1));
  assign idx_ext  = XW'(idx_q);
  assign in_range = (int'(idx_q) < CELLS);
  assign store_ch = (tab_q != '0) ? tccw_pkg::CH_SPACE : ch_q;
  assign blank_cell = {attr_i, tccw_pkg::CH_SPACE};

  always_comb begin
    if (req_q == tccw_pkg::REQ_READ) begin
      kind = tccw_pkg::CC_READ;
    end else begin
      case (ch_q)
        tccw_pkg::CH_NEWLINE:   kind = tccw_pkg::CC_NEWLINE;
        tccw_pkg::CH_RETURN:    kind = tccw_pkg::CC_RETURN;
        tccw_pkg::CH_BACKSPACE: kind = tccw_pkg::CC_BACKSPACE;
        tccw_pkg::CH_TAB:       kind = tccw_pkg::CC_TAB;
        default:                kind = tccw_pkg::CC_PRINT;
      endcase
    end
  end

  // cursor, tab count, sweep counter, clear flag
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    tab_d     = tab_q;
    clr_d     = clr_q;
    cleared_d = cleared_q;
    if (cmd_i.start) begin
      cleared_d = 1'b0;
      tab_d     = (kind == tccw_pkg::CC_TAB) ? tccw_pkg::TAB_WIDTH : '0;
    end
    if (cmd_i.newline) begin
      col_d = '0;
      if (!row_last) begin
        row_d = row_q + 1'b1;
      end
    end
    if (cmd_i.cr) begin
      col_d = '0;
    end
    if (cmd_i.bs_move) begin
      if (col_q == '0) begin
        if (row_q != '0) begin
          row_d = row_q - 1'b1;
          col_d = CW'(COLUMNS - 1);
        end
      end else begin
        col_d = col_q - 1'b1;
      end
    end
    if (cmd_i.store) begin
      if (tab_q != '0) begin
        tab_d = tab_q - 1'b1;
      end
      if (col_last) begin
        col_d = '0;
        if (!row_last) begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (cmd_i.init_step || cmd_i.clear_step) begin
      clr_d = clr_last ? '0 : clr_q + 1'b1;
    end
    if (cmd_i.clear_step) begin
      col_d     = '0;
      row_d     = '0;
      cleared_d = 1'b1;
    end
  end

  assign ram_we    = cmd_i.init_step | cmd_i.clear_step | cmd_i.store | cmd_i.bs_blank;
  assign ram_waddr = (cmd_i.init_step || cmd_i.clear_step) ? clr_q : pos;

  always_comb begin
    if (cmd_i.init_step) begin
      ram_wdata = '0;
    end else if (cmd_i.clear_step || cmd_i.bs_blank) begin
      ram_wdata = blank_cell;
    end else begin
      ram_wdata = {attr_i, store_ch};
    end
  end

  tccw_ram #(
    .WIDTH (tccw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      tab_q       <= '0;
      clr_q       <= '0;
      cleared_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      tab_q       <= tab_d;
      clr_q       <= clr_d;
      cleared_q   <= cleared_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      ch_q  <= char_code_i;
      idx_q <= cell_index_i;
    end
    if (cmd_i.out_load) begin
      out_pos_q  <= tccw_pkg::POS_W'(pos);
      out_data_q <= (req_q == tccw_pkg::REQ_READ && in_range) ? ram_rdata : '0;
      out_clr_q  <= cleared_q;
    end
  end

  assign status_o.kind        = kind;
  assign status_o.at_bottom   = row_last;
  assign status_o.wrap_bottom = col_last & row_last;
  assign status_o.tab_more    = (tab_q > tccw_pkg::TAB_CNT_W'(1));
  assign status_o.tab_pending = (tab_q != '0);
  assign status_o.clr_last    = clr_last;
  assign status_o.out_free    = ~out_valid_q | out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = out_pos_q;
  assign cell_data_o       = out_data_q;
  assign screen_cleared_o  = out_clr_q;

endmodule

// File: src/text_console_char_writer_top.sv
// Top level of the text console character writer: APB register, channels,
// controller and datapath. Depends on tccw_pkg, tccw_ifs, tccw_ctrl, tccw_dp.
//
// One request is handled at a time. A printable character goes through accept,
// decode, one cell write and result load; newline, carriage return and read
// skip the cell write, backspace moves the cursor and then blanks a cell, and
// tab makes one write per space through the single write port of the screen RAM.
// A request that runs the cursor off the bottom row adds a blanking sweep of
// COLUMNS*ROWS cells, one cell per cycle. After reset the screen RAM is zeroed
// by the same sweep, during which req_i.ready is low; register writes are taken
// meanwhile. The result register lets the next request be accepted while a
// result still waits on rsp_o.
`include "assert_macros.svh"

module text_console_char_writer_top #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tccw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tccw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tccw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  tccw_req_if.sink                            req_i,
  tccw_rsp_if.source                          rsp_o
);

  logic [tccw_pkg::ATTR_W-1:0] attr_q, attr_d;
  logic                        cfg_we;
  tccw_pkg::cmd_t              cmd;
  tccw_pkg::status_t           status;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == tccw_pkg::REG_IDX_COLOR);
  assign attr_d = cfg_we ? pwdata[tccw_pkg::ATTR_W-1:0] : attr_q;

  always_comb begin
    prdata = '0;
    if (paddr[2] == tccw_pkg::REG_IDX_COLOR) begin
      prdata = tccw_pkg::APB_DATA_W'(attr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tccw_pkg::ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tccw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .attr_i            (attr_q),
    .req_type_i        (req_i.req_type),
    .char_code_i       (req_i.char_code),
    .cell_index_i      (req_i.cell_index),
    .out_ready_i       (rsp_o.ready),
    .out_valid_o       (rsp_o.valid),
    .cursor_position_o (rsp_o.cursor_position),
    .cell_data_o       (rsp_o.cell_data),
    .screen_cleared_o  (rsp_o.screen_cleared)
  );

  `ASSERT_DEF(a_one_at_a_time, req_i.valid && req_i.ready |=> !req_i.ready, "request taken while busy")
  `ASSERT_DEF(a_read_never_clears, rsp_o.valid && rsp_o.cell_data != '0 |-> !rsp_o.screen_cleared, "read result flags clear")
  `ASSERT_DEF(a_attr_only_on_write, !cfg_we |=> $stable(attr_q), "attribute changed without write")

endmodule

// File: tb/sv/text_console_char_writer_checker.sv
`timescale 1ns / 100ps
// Checker for the text console character writer: tracks the color register
// and predicts each request's result. Depends on tccw_pkg and tccw_ifs.
module text_console_char_writer_checker import tccw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  tccw_req_if                   req_mon,
  tccw_rsp_if                   rsp_mon,
  output int                    errors_o,
  output int                    pending_o,
  output logic [POS_W-1:0]      cursor_o
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
    logic              screen_cleared;
  } console_result_t;

  logic [ATTR_W-1:0] attr_q;
  logic [CELL_W-1:0] screen_q [CELLS];
  int unsigned       col_q;
  int unsigned       row_q;
  logic              cleared_q;
  console_result_t   expected_q [$];
  int                errors_q = 0;

  function automatic logic [CELL_W-1:0] cell_of(logic [CHAR_W-1:0] ch);
    return {attr_q, ch};
  endfunction

  // no scrolling: running off the bottom blanks the screen and homes the cursor
  function automatic void next_row();
    row_q++;
    if (row_q >= ROWS) begin
      foreach (screen_q[i]) screen_q[i] = cell_of(CH_SPACE);
      col_q     = 0;
      row_q     = 0;
      cleared_q = 1'b1;
    end
  endfunction

  function automatic void store_glyph(logic [CHAR_W-1:0] ch);
    int unsigned pos;
    pos = row_q * COLUMNS + col_q;
    if (pos < CELLS) screen_q[pos] = cell_of(ch);
    col_q++;
    if (col_q >= COLUMNS) begin
      col_q = 0;
      next_row();
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors_q++;
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    console_result_t want;
    logic [CELL_W-1:0] data;
    if (!rst_ni) begin
      attr_q    = ATTR_RESET;
      col_q     = 0;
      row_q     = 0;
      cleared_q = 1'b0;
      foreach (screen_q[i]) screen_q[i] = '0;
      expected_q.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unrequested transaction, cursor_position",
                          rsp_mon.cursor_position, 0);
        end else begin
          want = expected_q.pop_front();
          if (rsp_mon.cursor_position !== want.cursor_position)
            report_mismatch("cursor_position", rsp_mon.cursor_position, want.cursor_position);
          if (rsp_mon.cell_data !== want.cell_data)
            report_mismatch("cell_data", rsp_mon.cell_data, want.cell_data);
          if (rsp_mon.screen_cleared !== want.screen_cleared)
            report_mismatch("screen_cleared", rsp_mon.screen_cleared, want.screen_cleared);
        end
      end

      if (psel && penable && pready && paddr[2] == REG_IDX_COLOR) begin
        if (pwrite) begin
          attr_q = pwdata[ATTR_W-1:0];
        end else if (prdata !== APB_DATA_W'(attr_q)) begin
          report_mismatch("color register read", prdata, attr_q);
        end
      end

      if (req_mon.valid && req_mon.ready) begin
        cleared_q = 1'b0;
        data      = '0;
        if (req_mon.req_type == REQ_PUT) begin
          case (req_mon.char_code)
            CH_NEWLINE: begin
              next_row();
              col_q = 0;
            end
            CH_RETURN: begin
              col_q = 0;
            end
            CH_BACKSPACE: begin
              if (col_q != 0) begin
                col_q--;
              end else if (row_q != 0) begin
                row_q--;
                col_q = COLUMNS - 1;
              end
              screen_q[row_q * COLUMNS + col_q] = cell_of(CH_SPACE);
            end
            CH_TAB: begin
              repeat (TAB_WIDTH) store_glyph(CH_SPACE);
            end
            default: begin
              store_glyph(req_mon.char_code);
            end
          endcase
        end else if (req_mon.cell_index < CELLS) begin
          data = screen_q[req_mon.cell_index];
        end
        want.cursor_position = POS_W'(row_q * COLUMNS + col_q);
        want.cell_data       = data;
        want.screen_cleared  = cleared_q;
        expected_q.push_back(want);
      end
    end
    errors_o  <= errors_q;
    pending_o <= expected_q.size();
    cursor_o  <= POS_W'(row_q * COLUMNS + col_q);
  end

endmodule

// File: tb/sv/text_console_char_writer_top_test.sv
`timescale 1ns / 100ps
// Top of the text console character writer test: clock, reset, request and
// register stimulus, verdict. Depends on tccw_pkg, tccw_ifs and the checker.
module text_console_char_writer_top_test;
  import tccw_pkg::*;

  localparam int COLUMNS     = COLUMNS_DEF;
  localparam int ROWS        = ROWS_DEF;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int QUIET_LIMIT = 20000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 85;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors;
  int                    pending;
  logic [POS_W-1:0]      cursor_pred;
  bit                    req_gaps;
  bit                    rsp_gaps;
  int                    stall_left;
  int                    quiet_cycles = 0;

  tccw_req_if req_if ();
  tccw_rsp_if rsp_if ();

  text_console_char_writer_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .rsp_o   (rsp_if)
  );

  text_console_char_writer_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) console_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_mon   (req_if),
    .rsp_mon   (rsp_if),
    .errors_o  (errors),
    .pending_o (pending),
    .cursor_o  (cursor_pred)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      rsp_if.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("text_console_char_writer_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(logic rtype, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
    if (req_gaps && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= rtype;
    req_if.char_code  <= ch;
    req_if.cell_index <= idx;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic put_char(logic [CHAR_W-1:0] ch);
    send_request(REQ_PUT, ch, IDX_W'($urandom_range(0, 2**IDX_W - 1)));
  endtask

  task automatic read_cell(logic [IDX_W-1:0] idx);
    send_request(REQ_READ, CHAR_W'($urandom_range(0, 255)), idx);
  endtask

  task automatic apb_access(logic wr, logic idx, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop issuing and wait until every transaction has its result
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // walk the cursor to the bottom-right corner, then tab or print across it
  task automatic head_for_bottom_corner();
    int unsigned row;
    drain();
    row = cursor_pred / COLUMNS;
    put_char(CH_RETURN);
    repeat (ROWS - 1 - row) put_char(CH_NEWLINE);
    repeat (COLUMNS / TAB_WIDTH - 1) put_char(CH_TAB);
    repeat ($urandom_range(0, 3)) put_char(CHAR_W'($urandom_range(8'h21, 8'h7E)));
    if ($urandom_range(0, 3) == 0) put_char(CHAR_W'($urandom_range(8'h21, 8'h7E)));
    else put_char(CH_TAB);
    read_cell(0);
    read_cell(1);
  endtask

  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) put_char(CHAR_W'($urandom_range(0, 255)));
    else if (pick < 45) put_char(CHAR_W'($urandom_range(8'h20, 8'h7E)));
    else if (pick < 63) put_char(CH_NEWLINE);
    else if (pick < 68) put_char(CH_RETURN);
    else if (pick < 76) put_char(CH_BACKSPACE);
    else if (pick < 83) put_char(CH_TAB);
    else if (pick < 95) read_cell(IDX_W'($urandom_range(0, CELLS - 1)));
    else read_cell(IDX_W'($urandom_range(CELLS, 2**IDX_W - 1)));
  endtask

  initial begin
    logic [ATTR_W-1:0] attr;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_PUT;
    req_if.char_code  <= '0;
    req_if.cell_index <= '0;
    req_gaps = 1'b0;
    rsp_gaps = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, REG_IDX_COLOR, '0);
    read_cell(0);
    read_cell(IDX_W'(CELLS - 1));
    read_cell(IDX_W'(CELLS));
    read_cell({IDX_W{1'b1}});
    put_char(CH_BACKSPACE);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CH_TAB);
    put_char(CH_RETURN);
    read_cell(1);
    read_cell(3);
    put_char(CH_NEWLINE);
    put_char(8'h7E);
    put_char(CH_BACKSPACE);
    put_char(CH_BACKSPACE);
    put_char(8'h5A);
    read_cell(IDX_W'(COLUMNS - 1));
    read_cell(IDX_W'(COLUMNS));
    put_char(CH_NEWLINE);
    put_char(CH_TAB);
    read_cell(IDX_W'(2 * COLUMNS + 3));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       attr = 8'h00;
        1:       attr = 8'hFF;
        default: attr = ATTR_W'($urandom_range(0, 255));
      endcase
      apb_access(1'b1, REG_IDX_COLOR, {24'($urandom), attr});
      if (p == 0) apb_access(1'b1, ~REG_IDX_COLOR, $urandom);
      apb_access(1'b0, REG_IDX_COLOR, '0);
      req_gaps = (p != 2) && (p != PHASES - 1);
      rsp_gaps = (p != 3) && (p != PHASES - 1);
      if (p < 3) head_for_bottom_corner();
      repeat (PHASE_ITEMS) random_request();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("text_console_char_writer_top test passed");
    end else begin
      $display("text_console_char_writer_top test failed");
    end
    $finish;
  end

endmodule
